/* src/bfc_pkg.sv */
`default_nettype none

package bfc_pkg;

    // Field widths
    localparam int IDX_W      = 12;
    localparam int MAG_W      = 16;
    localparam int FREQ_W     = 24;
    localparam int SPACING_W  = 23;
    localparam int TPH_W      = 48;
    localparam int OUT_W      = 17;
    localparam int PHASE_W    = 32;
    localparam int FRAC_W     = PHASE_W - 2;

    // Datapath widths
    localparam int CENTER_W    = IDX_W + SPACING_W;
    localparam int OFFSET_W    = CENTER_W + 2;
    localparam int PROD_W      = 56;
    localparam int TPH_HALF_W  = TPH_W / 2;
    localparam int PP_W        = OFFSET_W + TPH_HALF_W + 1;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int SINE_W      = 16;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = TPH_W;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIN_SPACING  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TURNS_PER_HZ = 1'b1;

    localparam logic [SPACING_W-1:0] BIN_SPACING_RST  = 23'd176400;
    localparam logic [TPH_W-1:0]     TURNS_PER_HZ_RST = 48'd409022986;

    // Parameter defaults
    localparam int MAX_BINS_DEF         = 4096;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic                     valid;
        logic [PHASE_W-1:0]       inc;
        logic signed [MAG_W-1:0]  mag;
    } bfc_item_t;

    typedef struct packed {
        logic                     valid;
        logic [PHASE_W-1:0]       phase;
        logic signed [MAG_W-1:0]  mag;
    } bfc_phase_t;

    // Quarter-wave entry: Taylor series to the t^11 term in Q30, rounded to Q15
    function automatic logic [SINE_W-1:0] sine_entry(input logic [63:0] t);
        logic [63:0]        tt;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] s;
        tt   = (t * t) >> 30;
        term = t;
        sum  = $signed(t);
        term = ((term * tt) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * tt) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * tt) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * tt) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * tt) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        if (sum < 64'sd0)
        begin
            sum = 64'sd0;
        end
        s = (sum + 64'sd16384) >>> 15;
        if (s > 64'sd32768)
        begin
            s = 64'sd32768;
        end
        return s[SINE_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/bfc_ram.sv */
`default_nettype none

module bfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/bfc_sine_rom.sv */
`default_nettype none

module bfc_sine_rom #(
    parameter int DEPTH = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic [$clog2(DEPTH+1)-1:0]       addr_a,
    input  wire logic [$clog2(DEPTH+1)-1:0]       addr_b,
    output logic      [bfc_pkg::SINE_W-1:0]       data_a,
    output logic      [bfc_pkg::SINE_W-1:0]       data_b
);

    logic [bfc_pkg::SINE_W-1:0] tab_w [DEPTH+1];
    logic [bfc_pkg::SINE_W-1:0] data_a_reg;
    logic [bfc_pkg::SINE_W-1:0] data_b_reg;

    // Entry k is sin(pi/2 * k / DEPTH)
    for (genvar k = 0; k <= DEPTH; k++)
    begin : g_entry
        localparam logic [63:0] T = (64'(k) * bfc_pkg::HALF_PI_Q30) / DEPTH;
        assign tab_w[k] = bfc_pkg::sine_entry(T);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_a_reg <= tab_w[addr_a];
            data_b_reg <= tab_w[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

`default_nettype wire

/* src/bfc_increment.sv */
`default_nettype none

module bfc_increment #(
    parameter int MAX_BINS = bfc_pkg::MAX_BINS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    input  wire logic                                 in_take,
    input  wire logic        [bfc_pkg::IDX_W-1:0]     bin_index,
    input  wire logic signed [bfc_pkg::MAG_W-1:0]     magnitude,
    input  wire logic signed [bfc_pkg::FREQ_W-1:0]    frequency,
    input  wire logic        [bfc_pkg::SPACING_W-1:0] bin_spacing,
    input  wire logic        [bfc_pkg::TPH_W-1:0]     turns_per_hz,
    output logic             [$clog2(MAX_BINS)-1:0]   rd_addr,
    output bfc_pkg::bfc_item_t                        item,
    output logic             [$clog2(MAX_BINS)-1:0]   item_slot
);

    localparam int ADDR_W = $clog2(MAX_BINS);
    localparam int IDX_W  = bfc_pkg::IDX_W;
    localparam int QP_W   = IDX_W + bfc_pkg::RECIP_W;
    localparam longint RECIP = (64'd1 << bfc_pkg::RECIP_SHIFT) / MAX_BINS;

    // Stage 1
    logic                              v1_reg;
    logic [IDX_W-1:0]                  idx1_reg;
    logic signed [bfc_pkg::MAG_W-1:0]  mag1_reg;
    logic signed [bfc_pkg::FREQ_W-1:0] freq1_reg;
    // Stage 2
    logic                              v2_reg;
    logic [bfc_pkg::CENTER_W-1:0]      center2_reg;
    logic [IDX_W-1:0]                  qest2_reg;
    logic [IDX_W-1:0]                  idx2_reg;
    logic signed [bfc_pkg::MAG_W-1:0]  mag2_reg;
    logic signed [bfc_pkg::FREQ_W-1:0] freq2_reg;
    // Stage 3
    logic                                v3_reg;
    logic signed [bfc_pkg::OFFSET_W-1:0] offset3_reg;
    logic [IDX_W-1:0]                    rem3_reg;
    logic signed [bfc_pkg::MAG_W-1:0]    mag3_reg;
    // Stage 4
    logic                              v4_reg;
    logic [bfc_pkg::PROD_W-1:0]        pplo4_reg;
    logic [bfc_pkg::PHASE_W-1:0]       pphi4_reg;
    logic [ADDR_W-1:0]                 slot4_reg;
    logic signed [bfc_pkg::MAG_W-1:0]  mag4_reg;
    // Stage 5
    logic                              v5_reg;
    logic [bfc_pkg::PHASE_W-1:0]       inc5_reg;
    logic [ADDR_W-1:0]                 slot5_reg;
    logic signed [bfc_pkg::MAG_W-1:0]  mag5_reg;

    logic [bfc_pkg::CENTER_W-1:0]        center2_next;
    logic [QP_W-1:0]                     qprod;
    logic signed [bfc_pkg::OFFSET_W-1:0] freq_ext;
    logic signed [bfc_pkg::OFFSET_W-1:0] center_ext;
    logic signed [bfc_pkg::OFFSET_W-1:0] offset3_next;
    logic [31:0]                         qm;
    logic [IDX_W-1:0]                    rem3_next;
    logic [31:0]                         rem_ext;
    logic [31:0]                         slot_full;
    logic [ADDR_W-1:0]                   slot3;
    logic signed [bfc_pkg::PP_W-1:0]     pp_lo_full;
    logic signed [bfc_pkg::PP_W-1:0]     pp_hi_full;
    logic [bfc_pkg::PROD_W-1:0]          prod4;
    logic [bfc_pkg::PROD_W-1:0]          rnd4;

    // Centre frequency and slot quotient estimate
    assign center2_next = bfc_pkg::CENTER_W'(idx1_reg) * bfc_pkg::CENTER_W'(bin_spacing);
    assign qprod        = QP_W'(idx1_reg) * QP_W'(RECIP);

    // Offset from centre; remainder is within one step of the true slot
    assign freq_ext     = bfc_pkg::OFFSET_W'(freq2_reg);
    assign center_ext   = $signed(bfc_pkg::OFFSET_W'(center2_reg));
    assign offset3_next = freq_ext - center_ext;
    assign qm           = 32'(qest2_reg) * 32'(MAX_BINS);
    assign rem3_next    = idx2_reg - qm[IDX_W-1:0];

    // Final slot correction and the two partial products of the increment
    assign rem_ext   = 32'(rem3_reg);
    assign slot_full = (rem_ext >= 32'(MAX_BINS)) ? (rem_ext - 32'(MAX_BINS)) : rem_ext;
    assign slot3     = slot_full[ADDR_W-1:0];
    assign rd_addr   = slot3;

    assign pp_lo_full = offset3_reg *
                        $signed({1'b0, turns_per_hz[bfc_pkg::TPH_HALF_W-1:0]});
    assign pp_hi_full = offset3_reg *
                        $signed({1'b0, turns_per_hz[bfc_pkg::TPH_W-1:bfc_pkg::TPH_HALF_W]});

    // Combine, round half up to Q32
    assign prod4 = pplo4_reg + {pphi4_reg, {bfc_pkg::TPH_HALF_W{1'b0}}};
    assign rnd4  = prod4 + (bfc_pkg::PROD_W'(1) << (bfc_pkg::TPH_HALF_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx1_reg    <= bin_index;
            mag1_reg    <= magnitude;
            freq1_reg   <= frequency;

            center2_reg <= center2_next;
            qest2_reg   <= qprod[bfc_pkg::RECIP_SHIFT +: IDX_W];
            idx2_reg    <= idx1_reg;
            mag2_reg    <= mag1_reg;
            freq2_reg   <= freq1_reg;

            offset3_reg <= offset3_next;
            rem3_reg    <= rem3_next;
            mag3_reg    <= mag2_reg;

            pplo4_reg   <= pp_lo_full[bfc_pkg::PROD_W-1:0];
            pphi4_reg   <= pp_hi_full[bfc_pkg::PHASE_W-1:0];
            slot4_reg   <= slot3;
            mag4_reg    <= mag3_reg;

            inc5_reg    <= rnd4[bfc_pkg::PROD_W-1 -: bfc_pkg::PHASE_W];
            slot5_reg   <= slot4_reg;
            mag5_reg    <= mag4_reg;
        end
    end

    assign item      = '{valid: v5_reg, inc: inc5_reg, mag: mag5_reg};
    assign item_slot = slot5_reg;

endmodule

`default_nettype wire

/* src/bfc_phase_acc.sv */
`default_nettype none

module bfc_phase_acc #(
    parameter int MAX_BINS = bfc_pkg::MAX_BINS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic [$clog2(MAX_BINS)-1:0]        rd_addr,
    input  wire bfc_pkg::bfc_item_t                 item,
    input  wire logic [$clog2(MAX_BINS)-1:0]        item_slot,
    output bfc_pkg::bfc_phase_t                     phase,
    output logic                                    clearing
);

    localparam int ADDR_W = $clog2(MAX_BINS);
    localparam int PW     = bfc_pkg::PHASE_W;

    logic                              clr_active_reg;
    logic [ADDR_W-1:0]                 clr_cnt_reg;
    logic [ADDR_W-1:0]                 slot4_reg;
    logic [PW-1:0]                     old5_reg;
    logic                              v6_reg;
    logic [PW-1:0]                     ph6_reg;
    logic [ADDR_W-1:0]                 slot6_reg;
    logic signed [bfc_pkg::MAG_W-1:0]  mag6_reg;

    logic [PW-1:0]     rd_data;
    logic [PW-1:0]     ph5;
    logic              hit5;
    logic              hit6;
    logic [PW-1:0]     old5_next;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PW-1:0]     wr_data;

    bfc_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_BINS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign ph5 = old5_reg + item.inc;

    // Bypass the store when a newer update to the same slot is still in flight
    assign hit5      = item.valid && (item_slot == slot4_reg);
    assign hit6      = v6_reg && (slot6_reg == slot4_reg);
    assign old5_next = hit5 ? ph5 : (hit6 ? ph6_reg : rd_data);

    assign wr_en   = clr_active_reg || (en && item.valid);
    assign wr_addr = clr_active_reg ? clr_cnt_reg : item_slot;
    assign wr_data = clr_active_reg ? '0 : ph5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            v6_reg         <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                if (clr_cnt_reg == ADDR_W'(MAX_BINS - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
                else
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
            end
            if (en)
            begin
                v6_reg <= item.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            slot4_reg <= rd_addr;
            old5_reg  <= old5_next;
            ph6_reg   <= ph5;
            slot6_reg <= item_slot;
            mag6_reg  <= item.mag;
        end
    end

    assign phase    = '{valid: v6_reg, phase: ph6_reg, mag: mag6_reg};
    assign clearing = clr_active_reg;

endmodule

`default_nettype wire

/* src/bfc_polar.sv */
`default_nettype none

module bfc_polar #(
    parameter int SINE_TABLE_DEPTH = bfc_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire bfc_pkg::bfc_phase_t               phase,
    output logic                                   out_valid,
    output logic signed [bfc_pkg::OUT_W-1:0]       real_part,
    output logic signed [bfc_pkg::OUT_W-1:0]       imag_part
);

    localparam int TIDX_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int MW     = bfc_pkg::MAG_W;
    localparam int VW     = bfc_pkg::SINE_W + 1;
    localparam int PRW    = MW + VW;

    logic                       v7_reg;
    logic [TIDX_W-1:0]          tidx7_reg;
    logic [1:0]                 quad7_reg;
    logic signed [MW-1:0]       mag7_reg;
    logic                       v8_reg;
    logic [1:0]                 quad8_reg;
    logic signed [MW-1:0]       mag8_reg;
    logic                       v9_reg;
    logic signed [PRW-1:0]      prod_s9_reg;
    logic signed [PRW-1:0]      prod_c9_reg;
    logic                       out_valid_reg;
    logic signed [bfc_pkg::OUT_W-1:0] real_reg;
    logic signed [bfc_pkg::OUT_W-1:0] imag_reg;

    logic [63:0]                fprod;
    logic [1:0]                 quad7_c;
    logic [TIDX_W-1:0]          mirror7;
    logic [TIDX_W-1:0]          addr_s;
    logic [TIDX_W-1:0]          addr_c;
    logic [bfc_pkg::SINE_W-1:0] rom_s;
    logic [bfc_pkg::SINE_W-1:0] rom_c;
    logic [1:0]                 quad8_c;
    logic signed [VW-1:0]       val_s;
    logic signed [VW-1:0]       val_c;
    logic signed [PRW-1:0]      prod_s9_next;
    logic signed [PRW-1:0]      prod_c9_next;
    logic signed [PRW-1:0]      rnd_s;
    logic signed [PRW-1:0]      rnd_c;

    // Table index from the fraction of the quadrant
    assign fprod = 64'(phase.phase[bfc_pkg::FRAC_W-1:0]) * 64'(SINE_TABLE_DEPTH);

    // Mirror on odd quadrants; cosine sits one quadrant ahead
    assign quad7_c = quad7_reg + 2'd1;
    assign mirror7 = TIDX_W'(SINE_TABLE_DEPTH) - tidx7_reg;
    assign addr_s  = quad7_reg[0] ? mirror7 : tidx7_reg;
    assign addr_c  = quad7_c[0] ? mirror7 : tidx7_reg;

    bfc_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .clk    (clk),
        .en     (en),
        .addr_a (addr_s),
        .addr_b (addr_c),
        .data_a (rom_s),
        .data_b (rom_c)
    );

    // Negate on the lower half turn, then scale by magnitude
    assign quad8_c      = quad8_reg + 2'd1;
    assign val_s        = quad8_reg[1] ? -$signed({1'b0, rom_s}) : $signed({1'b0, rom_s});
    assign val_c        = quad8_c[1] ? -$signed({1'b0, rom_c}) : $signed({1'b0, rom_c});
    assign prod_s9_next = mag8_reg * val_s;
    assign prod_c9_next = mag8_reg * val_c;

    // Round half up from Q30 to Q15
    assign rnd_s = prod_s9_reg + PRW'(16384);
    assign rnd_c = prod_c9_reg + PRW'(16384);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            v9_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v7_reg        <= phase.valid;
            v8_reg        <= v7_reg;
            v9_reg        <= v8_reg;
            out_valid_reg <= v9_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tidx7_reg   <= fprod[bfc_pkg::FRAC_W +: TIDX_W];
            quad7_reg   <= phase.phase[bfc_pkg::PHASE_W-1 -: 2];
            mag7_reg    <= phase.mag;

            quad8_reg   <= quad7_reg;
            mag8_reg    <= mag7_reg;

            prod_s9_reg <= prod_s9_next;
            prod_c9_reg <= prod_c9_next;

            real_reg    <= rnd_c[15 +: bfc_pkg::OUT_W];
            imag_reg    <= rnd_s[15 +: bfc_pkg::OUT_W];
        end
    end

    assign out_valid = out_valid_reg;
    assign real_part = real_reg;
    assign imag_part = imag_reg;

endmodule

`default_nettype wire

/* src/bin_frequency_to_cartesian_unit.sv */
`default_nettype none

// Phase vocoder resynthesis by phase accumulation. Each input word is one
// spectral bin (index, Q1.15 magnitude, Q.8 Hz true frequency). The unit
// removes the bin's centre frequency (bin_index * bin_spacing), scales the
// offset by turns_per_hz into a Q32 phase increment, adds it to that bin's
// phase accumulator (slot bin_index modulo MAX_BINS, wrapping at one turn),
// and returns magnitude * cos and magnitude * sin of the new phase from a
// quarter-wave table. Throughput is one word per clock while no result is
// held: the ten-stage pipeline is fully pipelined, and the accumulator
// read-modify-write is bypassed, so the same bin may arrive on consecutive
// cycles. Its depth is set by the split 37x48 increment multiply, the
// registered accumulator memory read and the registered sine table read.
// The whole pipeline advances whenever the output register is empty or
// being taken; while a result is held the input is stalled. After reset
// the accumulator memory is cleared, one entry per clock; in_stall stays
// high during that sweep, while configuration writes are taken at any
// time. Write configuration only when no word is in flight.

module bin_frequency_to_cartesian_unit #(
    parameter int MAX_BINS         = bfc_pkg::MAX_BINS_DEF,
    parameter int SINE_TABLE_DEPTH = bfc_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // input words
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic        [bfc_pkg::IDX_W-1:0]       bin_index,
    input  wire logic signed [bfc_pkg::MAG_W-1:0]       magnitude,
    input  wire logic signed [bfc_pkg::FREQ_W-1:0]      frequency,
    // result words
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed      [bfc_pkg::OUT_W-1:0]       real_part,
    output logic signed      [bfc_pkg::OUT_W-1:0]       imag_part,
    // configuration writes
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic        [bfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic        [bfc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W = $clog2(MAX_BINS);

    logic [bfc_pkg::SPACING_W-1:0] spacing_reg;
    logic [bfc_pkg::TPH_W-1:0]     tph_reg;

    logic                   en;
    logic                   clearing;
    logic                   in_take;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      item_slot;
    bfc_pkg::bfc_item_t     item;
    bfc_pkg::bfc_phase_t    phase;

    // Advance every stage together whenever the output register can move
    assign en       = !out_valid || !out_stall;
    // Hold off input words while stalled and during the accumulator clear
    assign in_stall = !en || clearing;
    assign in_take  = in_valid && !clearing;

    // Configuration registers; writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= bfc_pkg::BIN_SPACING_RST;
            tph_reg     <= bfc_pkg::TURNS_PER_HZ_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bfc_pkg::CFG_BIN_SPACING:  spacing_reg <= cfg_data[bfc_pkg::SPACING_W-1:0];
                bfc_pkg::CFG_TURNS_PER_HZ: tph_reg     <= cfg_data[bfc_pkg::TPH_W-1:0];
                default:                   ;
            endcase
        end
    end

    // Stages 1 to 5: centre offset, slot, phase increment
    bfc_increment #(
        .MAX_BINS (MAX_BINS)
    ) u_increment (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_take      (in_take),
        .bin_index    (bin_index),
        .magnitude    (magnitude),
        .frequency    (frequency),
        .bin_spacing  (spacing_reg),
        .turns_per_hz (tph_reg),
        .rd_addr      (rd_addr),
        .item         (item),
        .item_slot    (item_slot)
    );

    // Accumulator memory with bypass, plus the clearing sweep
    bfc_phase_acc #(
        .MAX_BINS (MAX_BINS)
    ) u_phase_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .rd_addr   (rd_addr),
        .item      (item),
        .item_slot (item_slot),
        .phase     (phase),
        .clearing  (clearing)
    );

    // Stages 7 to 10: sine table lookup and magnitude scaling
    bfc_polar #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_polar (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .phase     (phase),
        .out_valid (out_valid),
        .real_part (real_part),
        .imag_part (imag_part)
    );

`ifndef SYNTHESIS
    // No word can reach the output before the accumulators are cleared
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !out_valid)
        else $error("result word during accumulator clear");

    // A held result freezes the whole pipeline, so no input word may enter
    a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input word taken while result word held");

    // Accumulator bypass state only moves when the pipeline advances
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(phase))
        else $error("accumulator stage changed while stalled");
`endif

endmodule

`default_nettype wire

/* test/tb_bin_frequency_to_cartesian_unit.sv */
`timescale 1ns / 100ps

module tb_bin_frequency_to_cartesian_unit;

    import bfc_pkg::*;

    localparam int BINS        = 4096;
    localparam int TAB_DEPTH   = 1024;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int RANDOM_WORDS_PER_PHASE = 200;
    localparam int DRAIN_CYCLES = 20;

    // pi/2 in Q30, seed of the quarter-wave table
    localparam logic [63:0] HALF_PI_RAD_Q30 = 64'd1686629713;

    typedef struct packed {
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
    } cart_word_t;

    // Shadow of the unit: register copies, per-bin phase accumulators, the
    // sine table, and the queue of result words still owed by the unit.
    class cartesian_scoreboard;
        logic [SPACING_W-1:0] spacing;
        logic [TPH_W-1:0]     tph;
        logic [PHASE_W-1:0]   phase_acc [BINS];
        int                   quarter_wave [TAB_DEPTH+1];
        cart_word_t           owed_q [$];
        int                   mismatches;

        function new();
            spacing    = BIN_SPACING_RST;
            tph        = TURNS_PER_HZ_RST;
            mismatches = 0;
            foreach (phase_acc[i])
            begin
                phase_acc[i] = '0;
            end
            for (int k = 0; k <= TAB_DEPTH; k++)
            begin
                logic [63:0] x;
                logic [63:0] x2;
                logic [63:0] term;
                longint      acc;
                x    = (64'(k) * HALF_PI_RAD_Q30) / TAB_DEPTH;
                x2   = (x * x) >> 30;
                term = x;
                acc  = longint'(x);
                // alternate the odd Taylor terms up to x^11
                for (int n = 1; n <= 5; n++)
                begin
                    term = ((term * x2) >> 30) / 64'(2 * n * (2 * n + 1));
                    if (n % 2 == 1)
                    begin
                        acc = acc - longint'(term);
                    end
                    else
                    begin
                        acc = acc + longint'(term);
                    end
                end
                if (acc < 0)
                begin
                    acc = 0;
                end
                acc = (acc + 16384) >>> 15;
                quarter_wave[k] = (acc > 32768) ? 32768 : int'(acc);
            end
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] which, logic [CFG_DATA_W-1:0] value);
            if (which == CFG_BIN_SPACING)
            begin
                spacing = value[SPACING_W-1:0];
            end
            else if (which == CFG_TURNS_PER_HZ)
            begin
                tph = value[TPH_W-1:0];
            end
        endfunction

        function int wave_at(logic [PHASE_W-1:0] p);
            int unsigned idx;
            int          v;
            idx = int'((64'(p[FRAC_W-1:0]) * TAB_DEPTH) >> FRAC_W);
            v   = p[PHASE_W-2] ? quarter_wave[TAB_DEPTH - idx] : quarter_wave[idx];
            return p[PHASE_W-1] ? -v : v;
        endfunction

        function logic signed [OUT_W-1:0] to_q15(int m, int s);
            longint prod;
            prod = longint'(m) * s;
            prod = (prod + 16384) >>> 15;
            return prod[OUT_W-1:0];
        endfunction

        function void note_word(logic [IDX_W-1:0] bin, logic signed [MAG_W-1:0] mag,
                                logic signed [FREQ_W-1:0] freq);
            longint             offset;
            logic [63:0]        product;
            logic [PHASE_W-1:0] step;
            logic [PHASE_W-1:0] ph;
            int                 slot;
            cart_word_t         w;
            offset  = longint'(freq) - longint'(bin) * longint'(spacing);
            product = offset * {16'b0, tph};
            step    = PHASE_W'((product + 64'd8388608) >> 24);
            slot    = int'(bin) % BINS;
            ph      = phase_acc[slot] + step;
            phase_acc[slot] = ph;
            w.re = to_q15(int'(mag), wave_at(ph + 32'h4000_0000));
            w.im = to_q15(int'(mag), wave_at(ph));
            owed_q.push_back(w);
        endfunction

        function void complain(string msg);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("ERROR at %0t: %s", $realtime, msg);
            end
        endfunction

        function void check_word(logic signed [OUT_W-1:0] re, logic signed [OUT_W-1:0] im);
            cart_word_t want;
            if (owed_q.size() == 0)
            begin
                complain($sformatf("unexpected result word re %0d im %0d", re, im));
                return;
            end
            want = owed_q.pop_front();
            if (re !== want.re)
            begin
                complain($sformatf("real_part expected %0d actual %0d", want.re, re));
            end
            if (im !== want.im)
            begin
                complain($sformatf("imag_part expected %0d actual %0d", want.im, im));
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    // Clock and DUT pins; every input starts at a known value.
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [IDX_W-1:0]         bin_index = '0;
    logic signed [MAG_W-1:0]  magnitude = '0;
    logic signed [FREQ_W-1:0] frequency = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [OUT_W-1:0]  real_part;
    logic signed [OUT_W-1:0]  imag_part;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data  = '0;

    cartesian_scoreboard sb;

    // Idling knobs: sender is owned by the main process, receiver knob is
    // written with a nonblocking assignment since another process reads it.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Long receiver hold-off: requested once by the main process, counted
    // down by the receiver process.
    logic hold_request = 1'b0;
    logic hold_taken   = 1'b0;
    int   hold_left    = 0;

    int cycle_count = 0;

    // Random stream shape: short bin sweeps like an FFT frame, plus repeats.
    logic [SPACING_W-1:0] cur_spacing = BIN_SPACING_RST;
    logic [IDX_W-1:0]     last_bin    = '0;
    logic [IDX_W-1:0]     sweep_base  = '0;
    int                   sweep_pos   = 0;
    int                   sweep_len   = 0;

    bin_frequency_to_cartesian_unit #(
        .MAX_BINS         (BINS),
        .SINE_TABLE_DEPTH (TAB_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .bin_index (bin_index),
        .magnitude (magnitude),
        .frequency (frequency),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .real_part (real_part),
        .imag_part (imag_part),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watch every handshake on the pre-edge values: register writes update
    // the shadow registers, accepted input words are predicted, accepted
    // result words are checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                sb.set_reg(cfg_index, cfg_data);
            end
            if (in_valid && !in_stall)
            begin
                sb.note_word(bin_index, magnitude, frequency);
            end
            if (out_valid && !out_stall)
            begin
                sb.check_word(real_part, imag_part);
            end
        end
    end

    // Receiver: stall at random, or hold off for a long stretch once so that
    // the pipeline fills and the unit stalls its input.
    always @(posedge clk)
    begin
        if (hold_request && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD;
            out_stall  <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one input word, idling first at random; hold it until taken.
    // Valid stays high on return so a following word follows back to back.
    task automatic send_word(input logic [IDX_W-1:0] b, input logic signed [MAG_W-1:0] m,
                             input logic signed [FREQ_W-1:0] f);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        bin_index <= b;
        magnitude <= m;
        frequency <= f;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        last_bin = b;
    endtask

    // Drop valid and wait until every predicted result word has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Write both registers back to back; valid stays high between the two.
    task automatic write_regs(input logic [SPACING_W-1:0] spacing,
                              input logic [TPH_W-1:0] tph);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_BIN_SPACING;
        cfg_data  <= CFG_DATA_W'(spacing);
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_index <= CFG_TURNS_PER_HZ;
        cfg_data  <= tph;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid   <= 1'b0;
        cur_spacing = spacing;
    endtask

    // Build one random word: half from short bin sweeps, some repeating the
    // last bin (back-to-back accumulator hazards), the rest anywhere.
    // Frequencies mostly sit near the bin centre, like real analysis output.
    task automatic send_random_word();
        int                       pick;
        logic [IDX_W-1:0]         b;
        logic signed [MAG_W-1:0]  m;
        logic signed [FREQ_W-1:0] f;
        longint                   centre;
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            if (sweep_pos >= sweep_len)
            begin
                sweep_base = IDX_W'($urandom);
                sweep_len  = $urandom_range(1, 12);
                sweep_pos  = 0;
            end
            b = sweep_base + IDX_W'(sweep_pos);
            sweep_pos++;
        end
        else if (pick < 70)
        begin
            b = last_bin;
        end
        else
        begin
            b = IDX_W'($urandom);
        end

        case ($urandom_range(9))
            0: m = 16'sh8000;
            1: m = 16'sh7FFF;
            default: m = MAG_W'($urandom);
        endcase

        if ($urandom_range(3) != 0)
        begin
            centre = longint'(b) * longint'(cur_spacing)
                     + longint'($urandom_range(131071)) - 65536;
            f = centre[FREQ_W-1:0];
        end
        else
        begin
            f = FREQ_W'($urandom);
        end
        send_word(b, m, f);
    endtask

    initial
    begin
        sb = new();
        send_idle_pct = 17;
        recv_idle_pct <= 55;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: field extremes, phase zero on bin 0, the same bin
        // back to back, a word exactly at its bin centre, alternating bits.
        send_word(12'd0,    16'sh7FFF, 24'sh000000);
        send_word(12'd0,    16'sh8000, 24'sh000000);
        send_word(12'd4095, 16'sh8000, 24'sh800000);
        send_word(12'd4095, 16'sh7FFF, 24'sh7FFFFF);
        send_word(12'd1,    16'sh0000, 24'sd176400);
        send_word(12'd1,    16'sh5555, 24'sh2AAAAA);
        send_word(12'd2,    16'shAAAA, 24'shD55555);
        send_word(12'd2,    16'sh0001, 24'sh000001);
        send_word(12'd2,    16'shFFFF, 24'shFFFFFF);
        wait_drained();

        // Zero spacing and a quarter turn per Hz: 1 Hz steps a fresh bin by
        // exactly a quarter turn, so full-scale negative magnitude lands on
        // the table end and gives -32768 and then +32768.
        write_regs('0, 48'h4000_0000_0000);
        repeat (4) send_word(12'd77, 16'sh8000, 24'sd256);
        send_word(12'd78, 16'sh7FFF, 24'sd256);
        wait_drained();

        // Widest spacing with zero scale: phases must not move.
        write_regs('1, '0);
        send_word(12'd4095, 16'sh8000, 24'sh800000);
        send_word(12'd3000, 16'sd12345, 24'sh7FFFFF);
        wait_drained();

        // Random phase one: reset settings, long receiver hold-off midway.
        write_regs(BIN_SPACING_RST, TURNS_PER_HZ_RST);
        for (int i = 0; i < RANDOM_WORDS_PER_PHASE; i++)
        begin
            if (i == RANDOM_WORDS_PER_PHASE / 2)
            begin
                hold_request <= 1'b1;
            end
            send_random_word();
        end
        wait_drained();

        // Random phase two: idling swapped, both registers at full scale so
        // large offsets wrap the phase.
        send_idle_pct = 55;
        recv_idle_pct <= 17;
        write_regs('1, '1);
        for (int i = 0; i < RANDOM_WORDS_PER_PHASE; i++)
        begin
            send_random_word();
        end
        wait_drained();

        // Random phase three: no idling on either side, random settings.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        write_regs(SPACING_W'($urandom), TPH_W'({$urandom, $urandom}));
        for (int i = 0; i < RANDOM_WORDS_PER_PHASE; i++)
        begin
            send_random_word();
        end
        wait_drained();

        // Let any stray result word show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
